>>> hw/rtl/deq_pkg.sv
// ============================================================================
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ============================================================================
package deq_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // request opcodes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST_FWD   = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST_BWD   = 3'd5;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // cell data moves
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD      = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_SHIFT_UP  = 3'd1; // take left neighbor
    localparam logic [CELL_OP_W-1:0] CELL_SHIFT_DN  = 3'd2; // take right neighbor
    localparam logic [CELL_OP_W-1:0] CELL_ROT_DN    = 3'd3; // shift down, last takes front
    localparam logic [CELL_OP_W-1:0] CELL_LOAD_BACK = 3'd4; // first free cell loads

    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        logic                 grow;   // occupancy moves up by one
        logic                 shrink; // occupancy moves down by one
    } cell_ctrl_t;

endpackage

>>> hw/rtl/deq_in_if.sv
// ============================================================================
// deq_in_if
// Request channel: opcode and push value with valid/ready handshake.
// ============================================================================
interface deq_in_if;

    logic                          valid;
    logic                          ready;
    logic [deq_pkg::OP_W-1:0]      opcode;
    logic signed [deq_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);

endinterface

>>> hw/rtl/deq_out_if.sv
// ============================================================================
// deq_out_if
// Result channel: value, status, count and run marker with valid/ready.
// ============================================================================
interface deq_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::DATA_W-1:0] item_value;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic [deq_pkg::COUNT_W-1:0]       entry_count;
    logic                              last_of_run;

    modport source (output valid, output item_value, output status, output entry_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input item_value, input status, input entry_count,
                    input last_of_run, output ready);

endinterface

>>> hw/rtl/deq_cell.sv
// ============================================================================
// deq_cell
// One storage cell of the queue chain: a data word and an occupancy bit.
// ============================================================================
module deq_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  deq_pkg::cell_ctrl_t           ctrl,
    input  logic [deq_pkg::DATA_W-1:0]    left_data,
    input  logic                          left_valid,
    input  logic [deq_pkg::DATA_W-1:0]    right_data,
    input  logic                          right_valid,
    input  logic [deq_pkg::DATA_W-1:0]    head_data,
    input  logic [deq_pkg::DATA_W-1:0]    push_data,
    output logic [deq_pkg::DATA_W-1:0]    data,
    output logic                          valid,
    output logic                          last
);

    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::DATA_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;

    assign data  = data_reg;
    assign valid = valid_reg;
    assign last  = valid_reg & ~right_valid;

    always_comb
    begin
        case (ctrl.op)
            deq_pkg::CELL_SHIFT_UP:  data_next = left_data;
            deq_pkg::CELL_SHIFT_DN:  data_next = right_data;
            deq_pkg::CELL_ROT_DN:    data_next = last ? head_data : right_data;
            deq_pkg::CELL_LOAD_BACK: data_next = (!valid_reg && left_valid) ? push_data
                                                                             : data_reg;
            default:                 data_next = data_reg;
        endcase

        if (ctrl.grow)
            valid_next = left_valid;
        else if (ctrl.shrink)
            valid_next = right_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// ============================================================================
// double_ended_queue_unit
// Bounded deque of signed 32-bit values held in a chain of DEPTH cells.
// ============================================================================
//  channel | dir | fields                                          | handshake
//  --------+-----+-------------------------------------------------+----------
//  cmd     | in  | opcode[2:0], push_value[31:0]                    | valid/ready
//  result  | out | item_value[31:0], status[1:0], entry_count[4:0], | valid/ready
//          |     | last_of_run                                      |
//
//  Push and pop requests complete back to back while the result register
//  drains. A listing first enters the list state and then gives one result
//  per stored entry: the chain rotates by one cell per result and is back
//  in place at the end.
//  No request is taken while a listing runs. A stalled result holds the
//  result register; a new request waits until it is free or being taken.
//  Reset clears the occupancy bits, count and control; data is not cleared.
// ============================================================================
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    cmd,
    deq_out_if.source result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = deq_pkg::DATA_W;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_LIST = 1'b1;

    // cell chain
    deq_pkg::cell_ctrl_t ctrl;
    logic [DW-1:0]       shift_in;
    logic [DW-1:0]       push_data;
    logic [DW-1:0]       data_w  [DEPTH];
    logic [DEPTH-1:0]    valid_w;
    logic [DEPTH-1:0]    last_w;
    logic [DW-1:0]       back_value;

    // control
    logic [0:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] list_left_reg, list_left_next;
    logic          list_bwd_reg, list_bwd_next;

    // result register
    logic                            out_valid_reg;
    logic [DW-1:0]                   out_value_reg;
    logic [deq_pkg::STATUS_W-1:0]    out_status_reg;
    logic [deq_pkg::COUNT_W-1:0]     out_count_reg;
    logic                            out_last_reg;

    logic                            emit;
    logic [DW-1:0]                   emit_value;
    logic [deq_pkg::STATUS_W-1:0]    emit_status;
    logic [CW-1:0]                   emit_count;
    logic                            emit_last;
    logic [CW+deq_pkg::COUNT_W-1:0]  emit_count_ext;

    logic slot_free;
    logic accept;
    logic is_full;
    logic is_empty;

    assign push_data = cmd.push_value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DW-1:0] l_data;
            logic          l_valid;
            logic [DW-1:0] r_data;
            logic          r_valid;

            if (gi == 0)
            begin : g_first
                assign l_data  = shift_in;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data  = data_w[gi-1];
                assign l_valid = valid_w[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data  = data_w[gi+1];
                assign r_valid = valid_w[gi+1];
            end

            deq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .head_data   (data_w[0]),
                .push_data   (push_data),
                .data        (data_w[gi]),
                .valid       (valid_w[gi]),
                .last        (last_w[gi])
            );
        end
    endgenerate

    // back of the queue: the one cell flagged as last
    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
            back_value = back_value | (data_w[i] & {DW{last_w[i]}});
    end

    assign slot_free = !out_valid_reg || result.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        ctrl           = '{op: deq_pkg::CELL_HOLD, grow: 1'b0, shrink: 1'b0};
        shift_in       = cmd.push_value;
        state_next     = state_reg;
        count_next     = count_reg;
        list_left_next = list_left_reg;
        list_bwd_next  = list_bwd_reg;
        emit           = 1'b0;
        emit_value     = '0;
        emit_status    = deq_pkg::STAT_OK;
        emit_count     = count_reg;
        emit_last      = 1'b1;

        if (accept)
        begin
            case (cmd.opcode)
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                begin
                    emit = 1'b1;
                    if (is_full)
                        emit_status = deq_pkg::STAT_FULL;
                    else
                    begin
                        ctrl.op     = (cmd.opcode == deq_pkg::OP_PUSH_FRONT)
                                      ? deq_pkg::CELL_SHIFT_UP : deq_pkg::CELL_LOAD_BACK;
                        ctrl.grow   = 1'b1;
                        count_next  = count_reg + 1'b1;
                        emit_value  = cmd.push_value;
                        emit_count  = count_next;
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                begin
                    emit = 1'b1;
                    if (is_empty)
                        emit_status = deq_pkg::STAT_EMPTY;
                    else
                    begin
                        if (cmd.opcode == deq_pkg::OP_POP_FRONT)
                        begin
                            ctrl.op    = deq_pkg::CELL_SHIFT_DN;
                            emit_value = data_w[0];
                        end
                        else
                            emit_value = back_value;
                        ctrl.shrink = 1'b1;
                        count_next  = count_reg - 1'b1;
                        emit_count  = count_next;
                    end
                end
                deq_pkg::OP_LIST_FWD, deq_pkg::OP_LIST_BWD:
                begin
                    if (is_empty)
                    begin
                        emit        = 1'b1;
                        emit_status = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        state_next     = ST_LIST;
                        list_left_next = count_reg;
                        list_bwd_next  = (cmd.opcode == deq_pkg::OP_LIST_BWD);
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if ((state_reg == ST_LIST) && slot_free)
        begin
            // one entry per cycle while the result register is free; rotating the chain brings the next one up
            emit           = 1'b1;
            emit_last      = (list_left_reg == CW'(1));
            list_left_next = list_left_reg - 1'b1;
            if (list_bwd_reg)
            begin
                emit_value = back_value;
                ctrl.op    = deq_pkg::CELL_SHIFT_UP;
                shift_in   = back_value;
            end
            else
            begin
                emit_value = data_w[0];
                ctrl.op    = deq_pkg::CELL_ROT_DN;
            end
            if (emit_last)
                state_next = ST_IDLE;
        end
    end

    assign emit_count_ext = {{deq_pkg::COUNT_W{1'b0}}, emit_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            list_left_reg <= '0;
            list_bwd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_left_reg <= list_left_next;
            list_bwd_reg  <= list_bwd_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg  <= emit_value;
            out_status_reg <= emit_status;
            out_count_reg  <= emit_count_ext[deq_pkg::COUNT_W-1:0];
            out_last_reg   <= emit_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.item_value  = out_value_reg;
    assign result.status      = out_status_reg;
    assign result.entry_count = out_count_reg;
    assign result.last_of_run = out_last_reg;

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_w) == int'(count_reg))
        else $error("cell occupancy disagrees with count");

    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (!cmd.ready && (list_left_reg != '0)))
        else $error("request taken or empty run during listing");

    a_list_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> (count_reg == $past(count_reg)))
        else $error("count changed during listing");

endmodule
